// ----- hdl/pmsm_pkg.sv -----
// Shared constants, register indexes and saturation helper for the PMSM step model.
`timescale 1ns / 1ps
package pmsm_pkg;

  localparam int POLE_PAIRS = 4;
  localparam int INTEG_MODE = 2;
  localparam int SIG_FRAC   = 16;
  localparam int CFG_FRAC   = 24;

  localparam int CFG_IDX_W  = 4;

  localparam logic [CFG_IDX_W-1:0] REG_RESISTANCE = 4'd0;
  localparam logic [CFG_IDX_W-1:0] REG_D_IND      = 4'd1;
  localparam logic [CFG_IDX_W-1:0] REG_Q_IND      = 4'd2;
  localparam logic [CFG_IDX_W-1:0] REG_FLUX       = 4'd3;
  localparam logic [CFG_IDX_W-1:0] REG_INERTIA    = 4'd4;
  localparam logic [CFG_IDX_W-1:0] REG_FRICTION   = 4'd5;
  localparam logic [CFG_IDX_W-1:0] REG_BRAKE      = 4'd6;
  localparam logic [CFG_IDX_W-1:0] REG_TIME_STEP  = 4'd7;

  localparam logic [31:0] RST_RESISTANCE = 32'd8388608;
  localparam logic [31:0] RST_D_IND      = 32'd16777;
  localparam logic [31:0] RST_Q_IND      = 32'd16777;
  localparam logic [31:0] RST_FLUX       = 32'd1677722;
  localparam logic [31:0] RST_INERTIA    = 32'd1678;
  localparam logic [31:0] RST_FRICTION   = 32'd1678;
  localparam logic [31:0] RST_BRAKE      = 32'd0;
  localparam logic [31:0] RST_TIME_STEP  = 32'd168;

  // clamp a wide signed value to the signed 32-bit range
  function automatic logic signed [31:0] sat32(input logic signed [67:0] v);
    logic signed [67:0] hi;
    logic signed [67:0] lo;
    hi = 68'sh7FFFFFFF;
    lo = -68'sh80000000;
    if (v > hi) begin
      sat32 = 32'sh7FFFFFFF;
    end else if (v < lo) begin
      sat32 = 32'sh80000000;
    end else begin
      sat32 = v[31:0];
    end
  endfunction

endpackage

// ----- hdl/pmsm_in_if.sv -----
// Input channel: one word of d and q stator voltages.
`timescale 1ns / 1ps
interface pmsm_in_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] d_voltage;
  logic signed [31:0] q_voltage;

  modport source (output valid, d_voltage, q_voltage, input ready);
  modport sink   (input valid, d_voltage, q_voltage, output ready);
endinterface

// ----- hdl/pmsm_out_if.sv -----
// Result channel: one word of currents, torque, speed and angle.
`timescale 1ns / 1ps
interface pmsm_out_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] d_current;
  logic signed [31:0] q_current;
  logic signed [31:0] torque;
  logic signed [31:0] speed;
  logic signed [31:0] angle;

  modport source (output valid, d_current, q_current, torque, speed, angle, input ready);
  modport sink   (input valid, d_current, q_current, torque, speed, angle, output ready);
endinterface

// ----- hdl/pmsm_div.sv -----
// Radix-2 restoring divider: (|num| << CFG_FRAC) / den, signed and saturated result.
`timescale 1ns / 1ps
module pmsm_div (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  input  logic signed [31:0] num,
  input  logic        [31:0] den,
  output logic               done,
  output logic signed [31:0] quo
);
  localparam int DW = 32 + pmsm_pkg::CFG_FRAC;
  localparam int CW = $clog2(DW + 1);

  logic          busy_r;
  logic          done_r;
  logic [CW-1:0] cnt_r;
  logic [DW-1:0] dvd_r;
  logic [DW-1:0] q_r;
  logic [31:0]   rem_r;
  logic [31:0]   den_r;
  logic          neg_r;
  logic          zero_r;

  logic [31:0] mag;
  logic [32:0] trial;
  logic        fits;
  logic [32:0] diff;

  assign mag   = num[31] ? (~num + 32'd1) : num;
  assign trial = {rem_r, dvd_r[DW-1]};
  assign diff  = trial - {1'b0, den_r};
  assign fits  = (trial >= {1'b0, den_r});

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= CW'(DW);
        dvd_r  <= {mag, {pmsm_pkg::CFG_FRAC{1'b0}}};
        q_r    <= '0;
        rem_r  <= '0;
        den_r  <= den;
        neg_r  <= num[31];
        zero_r <= (den == 32'd0);
      end else if (busy_r) begin
        // shift in one dividend bit, subtract when the divisor fits
        rem_r <= fits ? diff[31:0] : trial[31:0];
        q_r   <= {q_r[DW-2:0], fits};
        dvd_r <= {dvd_r[DW-2:0], 1'b0};
        cnt_r <= cnt_r - CW'(1);
        if (cnt_r == CW'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_comb begin
    if (zero_r) begin
      quo = '0;
    end else if (neg_r) begin
      if (q_r > DW'(33'h080000000)) begin
        quo = 32'sh80000000;
      end else begin
        quo = -$signed(q_r[31:0]);
      end
    end else begin
      if (q_r > DW'(32'h7FFFFFFF)) begin
        quo = 32'sh7FFFFFFF;
      end else begin
        quo = $signed(q_r[31:0]);
      end
    end
  end

  assign done = done_r;

endmodule

// ----- hdl/pmsm_dq_motor_model_step.sv -----
// Top level: PMSM d/q frame motor model advanced one time step per input word.
`timescale 1ns / 1ps
// Usage:
//   in_chan  carries one word per time step: d_voltage and q_voltage (Q16.16).
//   out_chan returns one word per input: d_current, q_current, torque, speed
//   and angle (Q16.16, saturated). Both use valid/ready; a word moves at a
//   rising edge with valid and ready high.
//   cfg_we/cfg_idx/cfg_data write the eight Q8.24 model constants; indexes
//   beyond the list are dropped. Write only while the block is idle.
// Sequencing:
//   One word at a time. The step runs 16 products on one shared 33x33
//   multiplier (each a product register step, then shift/saturate and
//   accumulate) and 3 quotients on one radix-2 divider (CFG_FRAC+32 = 56
//   iterations each). in_chan.ready is high only while idle, so a new word
//   is taken only once the previous result has moved to the output register.
// Reset:
//   rst_n (synchronous, active low) clears the motor state and previous
//   slopes to zero and loads the constants with their default values.
// Stall:
//   The result sits in an output register; the next word is accepted while
//   it waits. If a new result is done before the old one is taken, hold it.
module pmsm_dq_motor_model_step (
  input  logic                                 clk,
  input  logic                                 rst_n,
  pmsm_in_if.sink                              in_chan,
  pmsm_out_if.source                           out_chan,
  input  logic                                 cfg_we,
  input  logic [pmsm_pkg::CFG_IDX_W-1:0]       cfg_idx,
  input  logic [31:0]                          cfg_data
);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MUL,
    ST_ACC,
    ST_DIVGO,
    ST_DIVWAIT
  } state_t;

  localparam int SH_W = 5;

  state_t state_r;
  logic [3:0] step_r;

  // model constants
  logic [31:0] res_r, ld_r, lq_r, flux_r, inertia_r, fric_r, brake_r, ts_r;

  // motor state
  logic signed [31:0] id_s_r, iq_s_r, w_s_r, ang_s_r;
  logic signed [31:0] last_d_r, last_q_r, last_w_r, last_wa_r;

  // working registers
  logic signed [31:0] vd_r, vq_r;
  logic signed [31:0] t1_r, t2_r;
  logic signed [39:0] acc_r;
  logic signed [31:0] d_slope_r, q_slope_r, w_slope_r;
  logic signed [31:0] id_n_r, iq_n_r, torque_r, w_n_r, th_n_r;
  logic [65:0]        prod_r;
  logic               neg_r;

  // output register
  logic               ov_r;
  logic signed [31:0] o_id_r, o_iq_r, o_tq_r, o_w_r, o_th_r;

  // shared multiplier operands
  logic signed [32:0] ma, mb;
  logic [32:0]        ma_mag, mb_mag;
  logic [SH_W-1:0]    sh;
  logic [65:0]        shv;
  logic signed [67:0] pv;
  logic signed [31:0] ps;
  logic signed [39:0] psx;
  logic signed [39:0] pp;
  logic signed [31:0] integ_x, integ_xp, integ_y;
  logic signed [31:0] integ_new;
  logic [63:0]        brk_wide;
  logic signed [31:0] brake_sig;

  logic               div_start;
  logic signed [31:0] div_num;
  logic [31:0]        div_den;
  logic               div_done;
  logic signed [31:0] div_quo;

  logic               in_acc;
  logic               out_free;

  localparam int BRK_R = (pmsm_pkg::CFG_FRAC >= pmsm_pkg::SIG_FRAC) ?
                         (pmsm_pkg::CFG_FRAC - pmsm_pkg::SIG_FRAC) : 0;
  localparam int BRK_L = (pmsm_pkg::CFG_FRAC >= pmsm_pkg::SIG_FRAC) ?
                         0 : (pmsm_pkg::SIG_FRAC - pmsm_pkg::CFG_FRAC);
  localparam int INTEG_SH = (pmsm_pkg::INTEG_MODE == 0 || pmsm_pkg::INTEG_MODE == 1) ?
                            pmsm_pkg::CFG_FRAC : pmsm_pkg::CFG_FRAC + 1;

  assign in_acc   = in_chan.valid && in_chan.ready;
  assign out_free = !ov_r || out_chan.ready;
  assign pp       = 40'(pmsm_pkg::POLE_PAIRS);

  // brake torque moved to the signal format
  assign brk_wide  = ({32'd0, brake_r} >> BRK_R) << BRK_L;
  assign brake_sig = (brk_wide > 64'h7FFFFFFF) ? 32'sh7FFFFFFF : $signed(brk_wide[31:0]);

  // integrator operands for the current step
  always_comb begin
    case (step_r)
      4'd7: begin
        integ_x = d_slope_r; integ_xp = last_d_r; integ_y = id_s_r;
      end
      4'd8: begin
        integ_x = q_slope_r; integ_xp = last_q_r; integ_y = iq_s_r;
      end
      4'd14: begin
        integ_x = w_slope_r; integ_xp = last_w_r; integ_y = w_s_r;
      end
      default: begin
        integ_x = w_n_r; integ_xp = last_wa_r; integ_y = ang_s_r;
      end
    endcase
  end

  // operand select for the shared multiplier
  always_comb begin
    ma = '0;
    mb = '0;
    sh = SH_W'(pmsm_pkg::CFG_FRAC);
    case (step_r)
      4'd0: begin
        ma = 33'(w_s_r); mb = 33'(iq_s_r); sh = SH_W'(pmsm_pkg::SIG_FRAC);
      end
      4'd1: begin
        ma = 33'(id_s_r); mb = {1'b0, res_r};
      end
      4'd2: begin
        ma = 33'(t1_r); mb = {1'b0, lq_r};
      end
      4'd3: begin
        ma = 33'(w_s_r); mb = 33'(id_s_r); sh = SH_W'(pmsm_pkg::SIG_FRAC);
      end
      4'd4: begin
        ma = 33'(iq_s_r); mb = {1'b0, res_r};
      end
      4'd5: begin
        ma = 33'(t1_r); mb = {1'b0, ld_r};
      end
      4'd6: begin
        ma = 33'(w_s_r); mb = {1'b0, flux_r};
      end
      4'd9: begin
        ma = 33'(iq_n_r); mb = {1'b0, flux_r};
      end
      4'd10: begin
        ma = 33'(id_n_r); mb = 33'(iq_n_r); sh = SH_W'(pmsm_pkg::SIG_FRAC);
      end
      4'd11: begin
        ma = 33'(t2_r); mb = {1'b0, ld_r} - {1'b0, lq_r};
      end
      4'd12: begin
        ma = 33'(t1_r) + 33'(t2_r); mb = 33'(3 * pmsm_pkg::POLE_PAIRS); sh = SH_W'(1);
      end
      4'd13: begin
        ma = 33'(w_s_r); mb = {1'b0, fric_r};
      end
      4'd7, 4'd8, 4'd14, 4'd15: begin
        mb = {1'b0, ts_r};
        sh = SH_W'(INTEG_SH);
        case (pmsm_pkg::INTEG_MODE)
          0:       ma = 33'(integ_xp);
          1:       ma = 33'(integ_x);
          default: ma = 33'(integ_x) + 33'(integ_xp);
        endcase
      end
      default: begin
        ma = '0;
      end
    endcase
  end

  assign ma_mag = ma[32] ? (~ma + 33'd1) : ma;
  assign mb_mag = mb[32] ? (~mb + 33'd1) : mb;

  // shift, sign and saturate the registered product
  assign shv       = prod_r >> sh;
  assign pv        = neg_r ? -$signed({2'b00, shv}) : $signed({2'b00, shv});
  assign ps        = pmsm_pkg::sat32(pv);
  assign psx       = 40'(ps);
  assign integ_new = pmsm_pkg::sat32(68'(integ_y) + pv);

  // slope numerator and divisor
  assign div_num   = pmsm_pkg::sat32(68'(acc_r));
  assign div_start = (state_r == ST_DIVGO);
  always_comb begin
    case (step_r)
      4'd2:    div_den = ld_r;
      4'd6:    div_den = lq_r;
      default: div_den = inertia_r;
    endcase
  end

  pmsm_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (div_start),
    .num   (div_num),
    .den   (div_den),
    .done  (div_done),
    .quo   (div_quo)
  );

  // configuration writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      res_r     <= pmsm_pkg::RST_RESISTANCE;
      ld_r      <= pmsm_pkg::RST_D_IND;
      lq_r      <= pmsm_pkg::RST_Q_IND;
      flux_r    <= pmsm_pkg::RST_FLUX;
      inertia_r <= pmsm_pkg::RST_INERTIA;
      fric_r    <= pmsm_pkg::RST_FRICTION;
      brake_r   <= pmsm_pkg::RST_BRAKE;
      ts_r      <= pmsm_pkg::RST_TIME_STEP;
    end else if (cfg_we) begin
      case (cfg_idx)
        pmsm_pkg::REG_RESISTANCE: res_r     <= cfg_data;
        pmsm_pkg::REG_D_IND:      ld_r      <= cfg_data;
        pmsm_pkg::REG_Q_IND:      lq_r      <= cfg_data;
        pmsm_pkg::REG_FLUX:       flux_r    <= cfg_data;
        pmsm_pkg::REG_INERTIA:    inertia_r <= cfg_data;
        pmsm_pkg::REG_FRICTION:   fric_r    <= cfg_data;
        pmsm_pkg::REG_BRAKE:      brake_r   <= cfg_data;
        pmsm_pkg::REG_TIME_STEP:  ts_r      <= cfg_data;
        default: ;
      endcase
    end
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= ST_IDLE;
      step_r    <= '0;
      ov_r      <= 1'b0;
      id_s_r    <= '0;
      iq_s_r    <= '0;
      w_s_r     <= '0;
      ang_s_r   <= '0;
      last_d_r  <= '0;
      last_q_r  <= '0;
      last_w_r  <= '0;
      last_wa_r <= '0;
    end else begin
      if (ov_r && out_chan.ready) begin
        ov_r <= 1'b0;
      end
      case (state_r)
        ST_IDLE: begin
          if (in_acc) begin
            vd_r    <= in_chan.d_voltage;
            vq_r    <= in_chan.q_voltage;
            step_r  <= '0;
            state_r <= ST_MUL;
          end
        end
        ST_MUL: begin
          prod_r  <= ma_mag * mb_mag;
          neg_r   <= ma[32] ^ mb[32];
          state_r <= ST_ACC;
        end
        ST_ACC: begin
          state_r <= ST_MUL;
          step_r  <= step_r + 4'd1;
          case (step_r)
            4'd0, 4'd3, 4'd9: t1_r <= ps;
            4'd10, 4'd11:     t2_r <= ps;
            4'd1: acc_r <= 40'(vd_r) - psx;
            4'd2: begin
              acc_r   <= acc_r + pp * psx;
              step_r  <= step_r;
              state_r <= ST_DIVGO;
            end
            4'd4: acc_r <= 40'(vq_r) - psx;
            4'd5: acc_r <= acc_r - pp * psx;
            4'd6: begin
              acc_r   <= acc_r - pp * psx;
              step_r  <= step_r;
              state_r <= ST_DIVGO;
            end
            4'd7:  id_n_r   <= integ_new;
            4'd8:  iq_n_r   <= integ_new;
            4'd12: torque_r <= ps;
            4'd13: begin
              acc_r   <= 40'(torque_r) - psx - 40'(brake_sig);
              step_r  <= step_r;
              state_r <= ST_DIVGO;
            end
            4'd14: w_n_r <= integ_new;
            default: begin
              // last step: hold until the output register is free
              step_r <= step_r;
              if (out_free) begin
                th_n_r    <= integ_new;
                o_id_r    <= id_n_r;
                o_iq_r    <= iq_n_r;
                o_tq_r    <= torque_r;
                o_w_r     <= w_n_r;
                o_th_r    <= integ_new;
                ov_r      <= 1'b1;
                id_s_r    <= id_n_r;
                iq_s_r    <= iq_n_r;
                w_s_r     <= w_n_r;
                ang_s_r   <= integ_new;
                last_d_r  <= d_slope_r;
                last_q_r  <= q_slope_r;
                last_w_r  <= w_slope_r;
                last_wa_r <= w_n_r;
                state_r   <= ST_IDLE;
              end else begin
                state_r <= ST_ACC;
              end
            end
          endcase
        end
        ST_DIVGO: begin
          state_r <= ST_DIVWAIT;
        end
        ST_DIVWAIT: begin
          if (div_done) begin
            case (step_r)
              4'd2:    d_slope_r <= div_quo;
              4'd6:    q_slope_r <= div_quo;
              default: w_slope_r <= div_quo;
            endcase
            step_r  <= step_r + 4'd1;
            state_r <= ST_MUL;
          end
        end
        default: state_r <= ST_IDLE;
      endcase
    end
  end

  assign in_chan.ready      = (state_r == ST_IDLE);
  assign out_chan.valid     = ov_r;
  assign out_chan.d_current = o_id_r;
  assign out_chan.q_current = o_iq_r;
  assign out_chan.torque    = o_tq_r;
  assign out_chan.speed     = o_w_r;
  assign out_chan.angle     = (th_n_r == o_th_r) ? th_n_r : o_th_r;

endmodule

// ----- tb/pmsm_tb_checker.sv -----
// Checker: predicts the motor model step and compares every result word.
`timescale 1ns / 1ps
module pmsm_tb_checker (
  input  logic       clk,
  input  logic       rst_n,
  pmsm_in_if         in_chan,
  pmsm_out_if        out_chan,
  input  logic       cfg_we,
  input  logic [3:0] cfg_idx,
  input  logic [31:0] cfg_data,
  output int         fail_count,
  output int         pending_count
);
  import pmsm_pkg::*;

  typedef struct packed {
    logic signed [31:0] id;
    logic signed [31:0] iq;
    logic signed [31:0] tq;
    logic signed [31:0] w;
    logic signed [31:0] th;
  } motor_word_t;

  motor_word_t       motor_words_due[$];
  logic [31:0]       r_res, r_ld, r_lq, r_flux, r_jm, r_fr, r_brk, r_ts;
  longint            s_id, s_iq, s_w, s_th, p_did, p_diq, p_dw, p_wth;

  function automatic longint clamp32(longint v);
    if (v > 64'sd2147483647) return 64'sd2147483647;
    if (v < -64'sd2147483648) return -64'sd2147483648;
    return v;
  endfunction

  function automatic longint mag(longint a);
    return (a < 0) ? -a : a;
  endfunction

  function automatic longint mul_trunc(longint a, longint b, int sh);
    logic [63:0] p;
    p = (64'(mag(a)) * 64'(mag(b))) >> sh;
    return (((a < 0) != (b < 0)) ? -longint'(p) : longint'(p));
  endfunction

  function automatic longint quot(longint num, logic [31:0] den);
    logic [63:0] q;
    if (den == 0) return 0;
    q = (64'(mag(num)) << CFG_FRAC) / {32'd0, den};
    return clamp32((num < 0) ? -longint'(q) : longint'(q));
  endfunction

  function automatic longint step_integ(longint y, longint x, longint xp);
    longint inc;
    if (INTEG_MODE == 0) inc = mul_trunc(xp, r_ts, CFG_FRAC);
    else if (INTEG_MODE == 1) inc = mul_trunc(x, r_ts, CFG_FRAC);
    else inc = mul_trunc(x + xp, r_ts, CFG_FRAC + 1);
    return clamp32(y + inc);
  endfunction

  function automatic motor_word_t advance_motor(longint vd, longint vq);
    longint p, num, dd, dq, id, iq, a, b, tq, dw, w, th, brk;
    motor_word_t o;
    p = POLE_PAIRS;
    num = vd - clamp32(mul_trunc(s_id, r_res, CFG_FRAC))
        + p * clamp32(mul_trunc(clamp32(mul_trunc(s_w, s_iq, SIG_FRAC)), r_lq, CFG_FRAC));
    dd = quot(clamp32(num), r_ld);
    num = vq - clamp32(mul_trunc(s_iq, r_res, CFG_FRAC))
        - p * clamp32(mul_trunc(clamp32(mul_trunc(s_w, s_id, SIG_FRAC)), r_ld, CFG_FRAC))
        - p * clamp32(mul_trunc(s_w, r_flux, CFG_FRAC));
    dq = quot(clamp32(num), r_lq);
    id = step_integ(s_id, dd, p_did);
    iq = step_integ(s_iq, dq, p_diq);
    p_did = dd; p_diq = dq;
    a = clamp32(mul_trunc(iq, r_flux, CFG_FRAC));
    b = clamp32(mul_trunc(clamp32(mul_trunc(id, iq, SIG_FRAC)),
                          longint'(r_ld) - longint'(r_lq), CFG_FRAC));
    tq = clamp32(mul_trunc(a + b, 3 * p, 1));
    brk = clamp32(longint'(r_brk >> (CFG_FRAC - SIG_FRAC)));
    num = tq - clamp32(mul_trunc(s_w, r_fr, CFG_FRAC)) - brk;
    dw = quot(clamp32(num), r_jm);
    w = step_integ(s_w, dw, p_dw);
    p_dw = dw;
    th = step_integ(s_th, w, p_wth);
    p_wth = w;
    s_id = id; s_iq = iq; s_w = w; s_th = th;
    o.id = id[31:0]; o.iq = iq[31:0]; o.tq = tq[31:0]; o.w = w[31:0]; o.th = th[31:0];
    return o;
  endfunction

  assign pending_count = motor_words_due.size();

  always @(posedge clk) begin
    motor_word_t got, want;
    if (!rst_n) begin
      r_res <= RST_RESISTANCE; r_ld <= RST_D_IND; r_lq <= RST_Q_IND;
      r_flux <= RST_FLUX; r_jm <= RST_INERTIA; r_fr <= RST_FRICTION;
      r_brk <= RST_BRAKE; r_ts <= RST_TIME_STEP;
      s_id = 0; s_iq = 0; s_w = 0; s_th = 0;
      p_did = 0; p_diq = 0; p_dw = 0; p_wth = 0;
      motor_words_due.delete();
      fail_count <= 0;
    end else begin
      if (cfg_we) begin
        case (cfg_idx)
          REG_RESISTANCE: r_res  <= cfg_data;
          REG_D_IND:      r_ld   <= cfg_data;
          REG_Q_IND:      r_lq   <= cfg_data;
          REG_FLUX:       r_flux <= cfg_data;
          REG_INERTIA:    r_jm   <= cfg_data;
          REG_FRICTION:   r_fr   <= cfg_data;
          REG_BRAKE:      r_brk  <= cfg_data;
          REG_TIME_STEP:  r_ts   <= cfg_data;
          default: ;
        endcase
      end
      if (in_chan.valid && in_chan.ready)
        motor_words_due.push_back(advance_motor(longint'(in_chan.d_voltage),
                                                longint'(in_chan.q_voltage)));
      if (out_chan.valid && out_chan.ready) begin
        got = {out_chan.d_current, out_chan.q_current, out_chan.torque,
               out_chan.speed, out_chan.angle};
        if (motor_words_due.size() == 0) begin
          fail_count <= fail_count + 1;
          if (fail_count < 10) $display("unexpected result word %h", got);
        end else begin
          want = motor_words_due.pop_front();
          if (got !== want) begin
            fail_count <= fail_count + 1;
            if (fail_count < 10)
              $display("mismatch: id %h/%h iq %h/%h tq %h/%h w %h/%h th %h/%h (exp/act)",
                       want.id, got.id, want.iq, got.iq, want.tq, got.tq,
                       want.w, got.w, want.th, got.th);
          end
        end
      end
    end
  end
endmodule

// ----- tb/testbench.sv -----
// Top: clock, reset, voltage stimulus, configuration phases and verdict.
`timescale 1ns / 1ps
module testbench;

  localparam logic [3:0] REG_UNKNOWN = 4'd9;

  logic        clk;
  logic        rst_n;
  logic        cfg_we;
  logic [3:0]  cfg_idx;
  logic [31:0] cfg_data;
  int          fail_count, pending_count;
  int          cycle_count;
  int          words_sent;
  int          stall_left;

  pmsm_in_if  in_chan();
  pmsm_out_if out_chan();

  pmsm_dq_motor_model_step u_dut (
    .clk(clk), .rst_n(rst_n), .in_chan(in_chan), .out_chan(out_chan),
    .cfg_we(cfg_we), .cfg_idx(cfg_idx), .cfg_data(cfg_data)
  );

  pmsm_tb_checker u_check (
    .clk(clk), .rst_n(rst_n), .in_chan(in_chan), .out_chan(out_chan),
    .cfg_we(cfg_we), .cfg_idx(cfg_idx), .cfg_data(cfg_data),
    .fail_count(fail_count), .pending_count(pending_count)
  );

  initial begin
    clk = 0;
    forever #1 clk = ~clk;
  end

  // Hard limit: one step per word plus random gaps on each side, about
  // 1350 words; allow about 5x.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > 6000000) begin
      $display("end of test: mismatches");
      $finish;
    end
  end

  function automatic int gap_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 40) return 0;
    if (r < 90) return $urandom_range(1, 5);
    return $urandom_range(20, 300);
  endfunction

  // Stall the result side at random: mostly short, now and then long.
  always @(posedge clk) begin
    if (stall_left > 0) begin
      out_chan.ready <= 1'b0;
      stall_left     <= stall_left - 1;
    end else if ($urandom_range(0, 1) == 0) begin
      out_chan.ready <= 1'b1;
    end else begin
      out_chan.ready <= 1'b0;
      stall_left     <= gap_len();
    end
  end

  // Send one word and hold it until accepted.
  task automatic send_voltage(logic [31:0] vd, logic [31:0] vq, bit idle_gaps);
    int g;
    g = idle_gaps ? gap_len() : 0;
    repeat (g) @(posedge clk);
    in_chan.valid     <= 1'b1;
    in_chan.d_voltage <= vd;
    in_chan.q_voltage <= vq;
    do @(posedge clk); while (!in_chan.ready);
    in_chan.valid <= 1'b0;
    words_sent++;
    // let the checker log the word before anything looks at the count
    @(posedge clk);
  endtask

  // Drain every expected word, then let the datapath settle before writes.
  task automatic wait_drained();
    while (pending_count != 0) @(posedge clk);
    repeat (250) @(posedge clk);
  endtask

  task automatic write_reg(logic [3:0] idx, logic [31:0] val);
    cfg_we   <= 1'b1;
    cfg_idx  <= idx;
    cfg_data <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  function automatic logic [31:0] rand_voltage();
    case ($urandom_range(0, 5))
      0: return 32'h7FFFFFFF;
      1: return 32'h80000000;
      2: return $urandom();
      default: return $signed($urandom_range(0, 40 << 16)) - (20 << 16);
    endcase
  endfunction

  function automatic logic [31:0] rand_reg(logic [31:0] nominal);
    case ($urandom_range(0, 5))
      0: return 32'd0;
      1: return 32'hFFFFFFFF;
      2: return $urandom();
      default: return nominal + $urandom_range(0, nominal);
    endcase
  endfunction

  initial begin
    logic [31:0] edge_v[4];
    int phase;
    edge_v = '{32'h7FFFFFFF, 32'h80000000, 32'h0, 32'h00010000};
    cycle_count = 0;
    words_sent = 0;
    stall_left = 0;
    rst_n = 0;
    cfg_we = 0; cfg_idx = 0; cfg_data = 0;
    in_chan.valid = 0; in_chan.d_voltage = 0; in_chan.q_voltage = 0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: voltage extremes against reset constants.
    foreach (edge_v[i]) foreach (edge_v[j]) send_voltage(edge_v[i], edge_v[j], 1'b0);
    wait_drained();

    // Zero divisors, and an unknown index that must be dropped.
    write_reg(pmsm_pkg::REG_D_IND, 32'd0);
    write_reg(pmsm_pkg::REG_Q_IND, 32'd0);
    write_reg(pmsm_pkg::REG_INERTIA, 32'd0);
    write_reg(REG_UNKNOWN, 32'h12345678);
    repeat (3) send_voltage(32'h00050000, 32'hFFFB0000, 1'b0);
    wait_drained();

    // Register extremes with saturating states.
    write_reg(pmsm_pkg::REG_RESISTANCE, 32'hFFFFFFFF);
    write_reg(pmsm_pkg::REG_D_IND, 32'd1);
    write_reg(pmsm_pkg::REG_Q_IND, 32'hFFFFFFFF);
    write_reg(pmsm_pkg::REG_FLUX, 32'hFFFFFFFF);
    write_reg(pmsm_pkg::REG_INERTIA, 32'd1);
    write_reg(pmsm_pkg::REG_FRICTION, 32'hFFFFFFFF);
    write_reg(pmsm_pkg::REG_BRAKE, 32'hFFFFFFFF);
    write_reg(pmsm_pkg::REG_TIME_STEP, 32'hFFFFFFFF);
    repeat (4) send_voltage(32'h7FFFFFFF, 32'h80000000, 1'b0);
    wait_drained();

    // Random phases; many near nominal constants so the motor actually spins.
    for (phase = 0; phase < 12; phase++) begin
      if (phase == 0) begin
        write_reg(pmsm_pkg::REG_RESISTANCE, pmsm_pkg::RST_RESISTANCE);
        write_reg(pmsm_pkg::REG_D_IND, pmsm_pkg::RST_D_IND);
        write_reg(pmsm_pkg::REG_Q_IND, pmsm_pkg::RST_Q_IND + 3000);
        write_reg(pmsm_pkg::REG_FLUX, pmsm_pkg::RST_FLUX);
        write_reg(pmsm_pkg::REG_INERTIA, pmsm_pkg::RST_INERTIA);
        write_reg(pmsm_pkg::REG_FRICTION, pmsm_pkg::RST_FRICTION);
        write_reg(pmsm_pkg::REG_BRAKE, 32'h00400000);
        write_reg(pmsm_pkg::REG_TIME_STEP, pmsm_pkg::RST_TIME_STEP * 10);
      end else begin
        write_reg(pmsm_pkg::REG_RESISTANCE, rand_reg(pmsm_pkg::RST_RESISTANCE));
        write_reg(pmsm_pkg::REG_D_IND, rand_reg(pmsm_pkg::RST_D_IND));
        write_reg(pmsm_pkg::REG_Q_IND, rand_reg(pmsm_pkg::RST_Q_IND));
        write_reg(pmsm_pkg::REG_FLUX, rand_reg(pmsm_pkg::RST_FLUX));
        write_reg(pmsm_pkg::REG_INERTIA, rand_reg(pmsm_pkg::RST_INERTIA));
        write_reg(pmsm_pkg::REG_FRICTION, rand_reg(pmsm_pkg::RST_FRICTION));
        write_reg(pmsm_pkg::REG_BRAKE, rand_reg(32'h00100000));
        write_reg(pmsm_pkg::REG_TIME_STEP, rand_reg(pmsm_pkg::RST_TIME_STEP * 20));
      end
      repeat (110) begin
        send_voltage(rand_voltage(), rand_voltage(), 1'b1);
        // Now and then hold off until every result is back.
        if ($urandom_range(0, 49) == 0)
          while (pending_count != 0) @(posedge clk);
      end
      wait_drained();
    end

    $display("covered %0d voltage words over directed and 12 random register phases,",
             words_sent);
    $display("with zero divisors, register extremes and random stalls on both sides");
    if (fail_count == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end
endmodule
